// ===== design/x86ild_pkg.sv =====
// ----------------------------------------------------------------------------
// x86ild_pkg
// Shared types, constants and decode functions of the x86 length decoder.
// ----------------------------------------------------------------------------
package x86ild_pkg;

  // leading prefix bytes at or beyond this count give length 0
  localparam int PREFIX_LIMIT = 16;
  localparam int WIN_BYTES    = 18;
  localparam int CNT_W        = $clog2(PREFIX_LIMIT + 1);
  localparam int IDX_W        = $clog2(WIN_BYTES + 1);
  localparam int LEN_W        = 5;

  // prefix bytes
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_CS    = 8'h2e;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3e;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;
  localparam logic [7:0] PFX_LOCK  = 8'hf0;
  localparam logic [7:0] PFX_REPNE = 8'hf2;
  localparam logic [7:0] PFX_REP   = 8'hf3;

  // two-byte opcodes
  localparam logic [7:0] OP_ESC  = 8'h0f;
  localparam logic [7:0] OP2_BT  = 8'hba;
  localparam logic [7:0] OP2_LSS = 8'hb2;
  localparam logic [7:0] OP2_LFS = 8'hb4;
  localparam logic [7:0] OP2_LGS = 8'hb5;

  // ModRM mod field
  localparam logic [1:0] MOD_IND  = 2'd0;
  localparam logic [1:0] MOD_D8   = 2'd1;
  localparam logic [1:0] MOD_DISP = 2'd2;
  localparam logic [1:0] MOD_REG  = 2'd3;
  localparam logic [2:0] RM_SIB   = 3'd4;
  localparam logic [2:0] RM_D32   = 3'd5;
  localparam logic [2:0] RM_D16   = 3'd6;
  localparam logic [2:0] BASE_NONE = 3'd5;

  typedef enum logic [3:0] {
    CLS_NONE,      // unsupported
    CLS_OP1,       // opcode only
    CLS_OP2,       // opcode + imm8/rel8
    CLS_IMMO,      // opcode + operand-size immediate
    CLS_MOFFS,     // opcode + address-size offset
    CLS_ENTER,     // fixed four bytes
    CLS_FAR,       // offset + selector
    CLS_MODRM,     // ModRM
    CLS_MODRM_I8,  // ModRM + imm8
    CLS_MODRM_IO,  // ModRM + operand-size immediate
    CLS_GRP3B,     // F6 group
    CLS_GRP3V      // F7 group
  } op_class_t;

  function automatic logic is_prefix(input logic [7:0] b);
    return (b == PFX_ES) || (b == PFX_CS) || (b == PFX_SS) || (b == PFX_DS) ||
           (b == PFX_FS) || (b == PFX_GS) || (b == PFX_OPSZ) || (b == PFX_ADSZ) ||
           (b == PFX_LOCK) || (b == PFX_REPNE) || (b == PFX_REP);
  endfunction

  function automatic op_class_t op_class(input logic [7:0] op);
    op_class_t c;
    c = CLS_NONE;
    if (op[7:6] == 2'b00) begin
      // ALU block: four ModRM forms, acc imm8, acc immediate, then one-byte ops
      case (op[2:0])
        3'd0, 3'd1, 3'd2, 3'd3: c = CLS_MODRM;
        3'd4:                   c = CLS_OP2;
        3'd5:                   c = CLS_IMMO;
        default:                c = CLS_OP1;
      endcase
      if (op == PFX_ES || op == PFX_CS || op == PFX_SS || op == PFX_DS ||
          op == OP_ESC) begin
        c = CLS_NONE;
      end
    end else begin
      case (op) inside
        [8'h40:8'h61]:                        c = CLS_OP1;
        8'h62, 8'h63:                         c = CLS_MODRM;
        [8'h64:8'h67]:                        c = CLS_NONE;
        8'h68:                                c = CLS_IMMO;
        8'h69:                                c = CLS_MODRM_IO;
        8'h6a:                                c = CLS_OP2;
        8'h6b:                                c = CLS_MODRM_I8;
        [8'h6c:8'h6f]:                        c = CLS_OP1;
        [8'h70:8'h7f]:                        c = CLS_OP2;
        8'h80, 8'h82, 8'h83:                  c = CLS_MODRM_I8;
        8'h81:                                c = CLS_MODRM_IO;
        [8'h84:8'h8f]:                        c = CLS_MODRM;
        8'h9a:                                c = CLS_FAR;
        [8'h90:8'h9f]:                        c = CLS_OP1;
        [8'ha0:8'ha3]:                        c = CLS_MOFFS;
        [8'ha4:8'ha7]:                        c = CLS_OP1;
        8'ha8:                                c = CLS_OP2;
        8'ha9:                                c = CLS_IMMO;
        [8'haa:8'haf]:                        c = CLS_OP1;
        [8'hb0:8'hb7]:                        c = CLS_OP2;
        [8'hb8:8'hbf]:                        c = CLS_IMMO;
        8'hc0, 8'hc1, 8'hc6:                  c = CLS_MODRM_I8;
        8'hc2, 8'hca:                         c = CLS_IMMO;
        8'hc3, 8'hc9, 8'hcb, 8'hcc, 8'hce, 8'hcf: c = CLS_OP1;
        8'hc4, 8'hc5:                         c = CLS_MODRM;
        8'hc7:                                c = CLS_MODRM_IO;
        8'hc8:                                c = CLS_ENTER;
        8'hcd:                                c = CLS_OP2;
        [8'hd0:8'hd3]:                        c = CLS_MODRM;
        8'hd4, 8'hd5:                         c = CLS_OP2;
        8'hd6, 8'hd7:                         c = CLS_OP1;
        [8'he0:8'he7], 8'heb:                 c = CLS_OP2;
        8'he8, 8'he9:                         c = CLS_IMMO;
        8'hea:                                c = CLS_FAR;
        [8'hec:8'hef]:                        c = CLS_OP1;
        8'hf1, 8'hf4, 8'hf5:                  c = CLS_OP1;
        8'hf6:                                c = CLS_GRP3B;
        8'hf7:                                c = CLS_GRP3V;
        [8'hf8:8'hfd]:                        c = CLS_OP1;
        8'hfe, 8'hff:                         c = CLS_MODRM;
        default:                              c = CLS_NONE;
      endcase
    end
    return c;
  endfunction

  // bytes of ModRM plus SIB and displacement
  function automatic logic [2:0] modrm_len(input logic [7:0] m, input logic [7:0] sib,
                                           input logic a32);
    logic [1:0] md;
    logic [2:0] rm;
    logic [2:0] n;
    md = m[7:6];
    rm = m[2:0];
    if (a32) begin
      if (md == MOD_REG)                        n = 3'd1;
      else if (md == MOD_IND && rm == RM_D32)   n = 3'd5;
      else if (rm == RM_SIB) begin
        if (md == MOD_D8)                       n = 3'd3;
        else if (md == MOD_DISP)                n = 3'd6;
        else                                    n = (sib[2:0] == BASE_NONE) ? 3'd6 : 3'd2;
      end
      else if (md == MOD_D8)                    n = 3'd2;
      else if (md == MOD_DISP)                  n = 3'd5;
      else                                      n = 3'd1;
    end else begin
      if (md == MOD_IND && rm == RM_D16)        n = 3'd3;
      else if (md == MOD_D8)                    n = 3'd2;
      else if (md == MOD_DISP)                  n = 3'd3;
      else                                      n = 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== design/x86ild_if.sv =====
// ----------------------------------------------------------------------------
// x86ild channel interfaces
// Valid/ready channels for code windows in and instruction lengths out.
// ----------------------------------------------------------------------------
interface x86ild_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] code_bytes_lo;
  logic [63:0] code_bytes_mid;
  logic [15:0] code_bytes_hi;
  logic        default_32;

  modport source (output valid, code_bytes_lo, code_bytes_mid, code_bytes_hi, default_32,
                  input ready);
  modport sink (input valid, code_bytes_lo, code_bytes_mid, code_bytes_hi, default_32,
                output ready);
endinterface

interface x86ild_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] length;

  modport source (output valid, length, input ready);
  modport sink (input valid, length, output ready);
endinterface

// ===== design/x86_instruction_length_decoder.sv =====
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder
// Three-stage pipeline: prefix scan, opcode byte select, class and length.
// ----------------------------------------------------------------------------
// Each item passes through the stage 1, stage 2 and stage 3 registers in
// order; its length leaves from the stage 3 register.
// Throughput: one item per cycle; the stages advance on a ready chain from
// the output register, so a stall holds the occupied stages and lets empty
// stages fill behind them.
// Reset: synchronous active-low rst_n clears the stage valid bits; the data
// registers are not reset.
module x86_instruction_length_decoder
  import x86ild_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  x86ild_in_if.sink         in_ch,
  x86ild_out_if.source      out_ch
);

  // stage enables
  logic en1, en2, en3;

  // stage 1: prefix scan
  logic             v1_r;
  logic [7:0]       win1_r [WIN_BYTES];
  logic [CNT_W-1:0] n1_r;
  logic             o32_1_r, a32_1_r, many1_r;
  logic [CNT_W-1:0] n1_nxt;
  logic             o32_1_nxt, a32_1_nxt, many1_nxt;

  // stage 2: bytes at the opcode
  logic             v2_r;
  logic [7:0]       b2_r [4];
  logic [CNT_W-1:0] n2_r;
  logic             o32_2_r, a32_2_r, many2_r;
  logic [7:0]       b2_nxt [4];

  // stage 3: length
  logic             v3_r;
  logic [LEN_W-1:0] length_r, length_nxt;

  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready  = en1;
  assign out_ch.valid = v3_r;
  assign out_ch.length = length_r;

  // ---------------- stage 1 ----------------
  logic [8*WIN_BYTES-1:0] flat;
  logic [7:0]             in_byte [WIN_BYTES];
  logic [PREFIX_LIMIT-1:0] lead;

  assign flat = {in_ch.code_bytes_hi, in_ch.code_bytes_mid, in_ch.code_bytes_lo};

  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      in_byte[k] = flat[8*k +: 8];
    end
  end

  always_comb begin
    o32_1_nxt = in_ch.default_32;
    a32_1_nxt = in_ch.default_32;
    n1_nxt    = CNT_W'(PREFIX_LIMIT);
    for (int k = 0; k < PREFIX_LIMIT; k++) begin
      lead[k] = is_prefix(in_byte[k]) && ((k == 0) ? 1'b1 : lead[(k == 0) ? 0 : k-1]);
    end
    for (int k = PREFIX_LIMIT - 1; k >= 0; k--) begin
      if (!lead[k]) n1_nxt = CNT_W'(k);
    end
    // each leading 66/67 toggles the size
    for (int k = 0; k < PREFIX_LIMIT; k++) begin
      if (lead[k] && in_byte[k] == PFX_OPSZ) o32_1_nxt = !o32_1_nxt;
      if (lead[k] && in_byte[k] == PFX_ADSZ) a32_1_nxt = !a32_1_nxt;
    end
    many1_nxt = lead[PREFIX_LIMIT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      win1_r  <= in_byte;
      n1_r    <= n1_nxt;
      o32_1_r <= o32_1_nxt;
      a32_1_r <= a32_1_nxt;
      many1_r <= many1_nxt;
    end
  end

  // ---------------- stage 2 ----------------
  logic [7:0]       ext [WIN_BYTES+1];
  logic [IDX_W-1:0] nsel;

  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      ext[k] = win1_r[k];
    end
    // a byte past the window reads as zero
    ext[WIN_BYTES] = 8'h00;
    nsel = many1_r ? '0 : IDX_W'(n1_r);
    for (int k = 0; k < 4; k++) begin
      b2_nxt[k] = ext[nsel + IDX_W'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      b2_r    <= b2_nxt;
      n2_r    <= n1_r;
      o32_2_r <= o32_1_r;
      a32_2_r <= a32_1_r;
      many2_r <= many1_r;
    end
  end

  // ---------------- stage 3 ----------------
  op_class_t        cls;
  logic [2:0]       ml1, ml2;
  logic [LEN_W-1:0] n5, immo, imma, grp_imm;

  always_comb begin
    cls  = op_class(b2_r[0]);
    ml1  = modrm_len(b2_r[1], b2_r[2], a32_2_r);
    ml2  = modrm_len(b2_r[2], b2_r[3], a32_2_r);
    n5   = LEN_W'(n2_r);
    immo = o32_2_r ? LEN_W'(4) : LEN_W'(2);
    imma = a32_2_r ? LEN_W'(4) : LEN_W'(2);
    grp_imm = '0;
    length_nxt = '0;
    if (many2_r) begin
      length_nxt = '0;
    end else if (b2_r[0] == OP_ESC) begin
      if (b2_r[1] == OP2_BT) begin
        length_nxt = n5 + LEN_W'(3) + LEN_W'(ml2);
      end else if (b2_r[1] == OP2_LSS || b2_r[1] == OP2_LFS || b2_r[1] == OP2_LGS) begin
        length_nxt = n5 + LEN_W'(2) + LEN_W'(ml2);
      end else begin
        length_nxt = '0;
      end
    end else begin
      // test immediate only for ModRM reg 0 or 1
      if (b2_r[1][5:4] == 2'b00) begin
        grp_imm = (cls == CLS_GRP3B) ? LEN_W'(1) : immo;
      end
      case (cls)
        CLS_OP1:       length_nxt = n5 + LEN_W'(1);
        CLS_OP2:       length_nxt = n5 + LEN_W'(2);
        CLS_IMMO:      length_nxt = n5 + LEN_W'(1) + immo;
        CLS_MOFFS:     length_nxt = n5 + LEN_W'(1) + imma;
        CLS_ENTER:     length_nxt = n5 + LEN_W'(4);
        CLS_FAR:       length_nxt = n5 + LEN_W'(3) + immo;
        CLS_MODRM:     length_nxt = n5 + LEN_W'(1) + LEN_W'(ml1);
        CLS_MODRM_I8:  length_nxt = n5 + LEN_W'(2) + LEN_W'(ml1);
        CLS_MODRM_IO:  length_nxt = n5 + LEN_W'(1) + LEN_W'(ml1) + immo;
        CLS_GRP3B,
        CLS_GRP3V:     length_nxt = n5 + LEN_W'(1) + LEN_W'(ml1) + grp_imm;
        default:       length_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      length_r <= length_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_too_many_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en3 && many2_r) |=> (length_r == '0))
    else $error("too many prefixes must give length 0");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (length_r <= LEN_W'(26)))
    else $error("length out of range");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !many1_r) |-> (n1_r < CNT_W'(PREFIX_LIMIT)))
    else $error("prefix count inconsistent with limit flag");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ch.ready) |=> (v3_r && $stable(length_r)))
    else $error("output register changed during stall");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en2) |=> (v2_r && $stable(n2_r) && $stable(many2_r)))
    else $error("stage 2 lost its item during stall");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86 instruction length decoder testbench
// Feeds code windows through the valid/ready input channel and checks each
// decoded length against an in-bench length predictor, with random idling on
// both channels and a drain pause late in the run.
// ----------------------------------------------------------------------------
module testbench;
  import x86ild_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int PIPE_LATENCY = 3;
  localparam int QUIET_LIMIT  = 1000;

  typedef struct {
    logic [143:0] window;
    logic         d32;
    logic [4:0]   length;
  } length_expect_t;

  logic clk = 1'b0;
  logic rst_n;

  x86ild_in_if  in_ch ();
  x86ild_out_if out_ch ();

  x86_instruction_length_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  length_expect_t pending_lengths[$];
  int gap_pct       = 12;
  int stall_pct     = 12;
  int mismatches    = 0;
  int windows_sent  = 0;
  int windows_16bit = 0;
  int zero_lengths  = 0;
  int longest       = 0;
  int quiet_cycles  = 0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] win_byte(input logic [143:0] w, input int k);
    if (k < WIN_BYTES) return w[8*k +: 8];
    return 8'h00;
  endfunction

  function automatic logic prefix_byte(input logic [7:0] b);
    case (b)
      PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
      PFX_OPSZ, PFX_ADSZ, PFX_LOCK, PFX_REPNE, PFX_REP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic op_class_t class_of(input logic [7:0] op);
    op_class_t c;
    c = CLS_NONE;
    case (op[7:4])
      4'h0, 4'h1, 4'h2, 4'h3: begin
        case (op[2:0])
          3'd4:       c = CLS_OP2;
          3'd5:       c = CLS_IMMO;
          3'd6, 3'd7: c = CLS_OP1;
          default:    c = CLS_MODRM;
        endcase
        if (op == OP_ESC || prefix_byte(op)) c = CLS_NONE;
      end
      4'h4, 4'h5: c = CLS_OP1;
      4'h6: begin
        case (op[3:0])
          4'h0, 4'h1:             c = CLS_OP1;
          4'h2, 4'h3:             c = CLS_MODRM;
          4'h8:                   c = CLS_IMMO;
          4'h9:                   c = CLS_MODRM_IO;
          4'ha:                   c = CLS_OP2;
          4'hb:                   c = CLS_MODRM_I8;
          4'hc, 4'hd, 4'he, 4'hf: c = CLS_OP1;
          default:                c = CLS_NONE;
        endcase
      end
      4'h7: c = CLS_OP2;
      4'h8: begin
        case (op[3:0])
          4'h0, 4'h2, 4'h3: c = CLS_MODRM_I8;
          4'h1:             c = CLS_MODRM_IO;
          default:          c = CLS_MODRM;
        endcase
      end
      4'h9: c = (op[3:0] == 4'ha) ? CLS_FAR : CLS_OP1;
      4'ha: begin
        case (op[3:0])
          4'h0, 4'h1, 4'h2, 4'h3: c = CLS_MOFFS;
          4'h8:                   c = CLS_OP2;
          4'h9:                   c = CLS_IMMO;
          default:                c = CLS_OP1;
        endcase
      end
      4'hb: c = op[3] ? CLS_IMMO : CLS_OP2;
      4'hc: begin
        case (op[3:0])
          4'h0, 4'h1, 4'h6: c = CLS_MODRM_I8;
          4'h2, 4'ha:       c = CLS_IMMO;
          4'h4, 4'h5:       c = CLS_MODRM;
          4'h7:             c = CLS_MODRM_IO;
          4'h8:             c = CLS_ENTER;
          4'hd:             c = CLS_OP2;
          default:          c = CLS_OP1;
        endcase
      end
      4'hd: begin
        case (op[3:0])
          4'h0, 4'h1, 4'h2, 4'h3: c = CLS_MODRM;
          4'h4, 4'h5:             c = CLS_OP2;
          4'h6, 4'h7:             c = CLS_OP1;
          default:                c = CLS_NONE;
        endcase
      end
      4'he: begin
        case (op[3:0])
          4'h8, 4'h9:             c = CLS_IMMO;
          4'ha:                   c = CLS_FAR;
          4'hb:                   c = CLS_OP2;
          4'hc, 4'hd, 4'he, 4'hf: c = CLS_OP1;
          default:                c = CLS_OP2;
        endcase
      end
      default: begin
        case (op[3:0])
          4'h6:             c = CLS_GRP3B;
          4'h7:             c = CLS_GRP3V;
          4'he, 4'hf:       c = CLS_MODRM;
          4'h0, 4'h2, 4'h3: c = CLS_NONE;
          default:          c = CLS_OP1;
        endcase
      end
    endcase
    return c;
  endfunction

  // ModRM byte at position k plus any SIB and displacement bytes
  function automatic int addr_bytes(input logic [143:0] w, input int k, input logic a32);
    logic [7:0] m;
    logic [7:0] sib;
    m   = win_byte(w, k);
    sib = win_byte(w, k + 1);
    if (a32) begin
      if (m[7:6] == MOD_REG) return 1;
      if (m[7:6] == MOD_IND && m[2:0] == RM_D32) return 5;
      if (m[2:0] == RM_SIB) begin
        if (m[7:6] == MOD_D8) return 3;
        if (m[7:6] == MOD_DISP) return 6;
        // sib with no base register carries its own disp32
        return (sib[2:0] == BASE_NONE) ? 6 : 2;
      end
      if (m[7:6] == MOD_D8) return 2;
      if (m[7:6] == MOD_DISP) return 5;
      return 1;
    end
    if (m[7:6] == MOD_IND && m[2:0] == RM_D16) return 3;
    if (m[7:6] == MOD_D8) return 2;
    if (m[7:6] == MOD_DISP) return 3;
    return 1;
  endfunction

  function automatic logic [4:0] predict_length(input logic [143:0] w, input logic d32);
    int         n;
    int         len;
    int         imm_o;
    int         imm_a;
    int         ab;
    logic       o32;
    logic       a32;
    logic [7:0] b;
    logic [7:0] op;
    logic [7:0] nxt;
    o32 = d32;
    a32 = d32;
    n   = 0;
    b   = win_byte(w, 0);
    while (n < PREFIX_LIMIT && prefix_byte(b)) begin
      if (b == PFX_OPSZ) o32 = !o32;
      if (b == PFX_ADSZ) a32 = !a32;
      n++;
      b = win_byte(w, n);
    end
    if (n >= PREFIX_LIMIT) return 5'd0;
    imm_o = o32 ? 4 : 2;
    imm_a = a32 ? 4 : 2;
    op    = win_byte(w, n);
    nxt   = win_byte(w, n + 1);
    if (op == OP_ESC) begin
      if (nxt == OP2_BT)
        len = n + 3 + addr_bytes(w, n + 2, a32);
      else if (nxt == OP2_LSS || nxt == OP2_LFS || nxt == OP2_LGS)
        len = n + 2 + addr_bytes(w, n + 2, a32);
      else
        len = 0;
      return len[4:0];
    end
    ab = addr_bytes(w, n + 1, a32);
    case (class_of(op))
      CLS_OP1:      len = n + 1;
      CLS_OP2:      len = n + 2;
      CLS_IMMO:     len = n + 1 + imm_o;
      CLS_MOFFS:    len = n + 1 + imm_a;
      CLS_ENTER:    len = n + 4;
      CLS_FAR:      len = n + 3 + imm_o;
      CLS_MODRM:    len = n + 1 + ab;
      CLS_MODRM_I8: len = n + 2 + ab;
      CLS_MODRM_IO: len = n + 1 + ab + imm_o;
      // test forms (reg 0 or 1) are the only group members with an immediate
      CLS_GRP3B:    len = n + 1 + ab + ((nxt[5:3] <= 3'd1) ? 1 : 0);
      CLS_GRP3V:    len = n + 1 + ab + ((nxt[5:3] <= 3'd1) ? imm_o : 0);
      default:      len = 0;
    endcase
    return len[4:0];
  endfunction

  // ---------------------------------------------------------------- window helpers

  function automatic logic [143:0] rand_window();
    logic [143:0] w;
    for (int k = 0; k < WIN_BYTES; k++) w[8*k +: 8] = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic logic [7:0] pick_prefix();
    case ($urandom_range(10))
      0:       return PFX_ES;
      1:       return PFX_CS;
      2:       return PFX_SS;
      3:       return PFX_DS;
      4:       return PFX_FS;
      5:       return PFX_GS;
      6:       return PFX_OPSZ;
      7:       return PFX_ADSZ;
      8:       return PFX_LOCK;
      9:       return PFX_REPNE;
      default: return PFX_REP;
    endcase
  endfunction

  // seq is written in byte order, first byte in the most significant used position
  function automatic logic [143:0] put_bytes(input logic [143:0] w, input int at,
                                             input logic [63:0] seq, input int cnt);
    for (int i = 0; i < cnt; i++)
      if (at + i < WIN_BYTES) w[8*(at+i) +: 8] = seq[8*(cnt-1-i) +: 8];
    return w;
  endfunction

  function automatic logic [143:0] prefix_run(input logic [143:0] w, input int cnt,
                                              input logic [7:0] b);
    for (int k = 0; k < cnt; k++) w[8*k +: 8] = b;
    return w;
  endfunction

  task automatic gen_instruction(output logic [143:0] w, output logic d32);
    int npfx;
    int pos;
    int r;
    w   = rand_window();
    d32 = 1'($urandom_range(1));
    // plain noise window now and then
    if ($urandom_range(99) < 10) return;
    r = $urandom_range(99);
    if (r < 50) npfx = 0;
    else if (r < 85) npfx = $urandom_range(3, 1);
    else if (r < 95) npfx = $urandom_range(15, 4);
    else npfx = $urandom_range(WIN_BYTES, PREFIX_LIMIT);
    for (int k = 0; k < npfx; k++) w[8*k +: 8] = pick_prefix();
    if (npfx >= WIN_BYTES) return;
    pos = npfx;
    r = $urandom_range(99);
    if (r < 20) begin
      w[8*pos +: 8] = OP_ESC;
      if (pos + 1 < WIN_BYTES) begin
        case ($urandom_range(4))
          0: w[8*(pos+1) +: 8] = OP2_BT;
          1: w[8*(pos+1) +: 8] = OP2_LSS;
          2: w[8*(pos+1) +: 8] = OP2_LFS;
          3: w[8*(pos+1) +: 8] = OP2_LGS;
          default: ;
        endcase
      end
      pos = pos + 2;
    end else if (r < 30) begin
      w[8*pos +: 8] = $urandom_range(1) ? 8'hf6 : 8'hf7;
      pos = pos + 1;
    end else begin
      pos = pos + 1;
    end
    // steer the modrm toward sib forms, half of them without a base
    if (pos < WIN_BYTES && $urandom_range(3) == 0) begin
      w[8*pos +: 3] = RM_SIB;
      if (pos + 1 < WIN_BYTES && $urandom_range(1) == 1) w[8*(pos+1) +: 3] = BASE_NONE;
    end
  endtask

  // ---------------------------------------------------------------- channels

  task automatic send_window(input logic [143:0] w, input logic d32);
    length_expect_t e;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.code_bytes_lo  <= w[63:0];
    in_ch.code_bytes_mid <= w[127:64];
    in_ch.code_bytes_hi  <= w[143:128];
    in_ch.default_32     <= d32;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    e.window = w;
    e.d32    = d32;
    e.length = predict_length(w, d32);
    pending_lengths.push_back(e);
    windows_sent++;
    if (!d32) windows_16bit++;
    if (e.length == 5'd0) zero_lengths++;
    if (int'(e.length) > longest) longest = int'(e.length);
  endtask

  task automatic wait_for_lengths();
    while (pending_lengths.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_lengths
    length_expect_t e;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_lengths.size() == 0) begin
        report_mismatch($sformatf("length %0d with no window outstanding", out_ch.length));
      end else begin
        e = pending_lengths.pop_front();
        if (out_ch.length !== e.length)
          report_mismatch($sformatf("window %036h d32 %0b: length %0d, expected %0d",
                                    e.window, e.d32, out_ch.length, e.length));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without an accepted item", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    logic [143:0] w;
    send_window('0, 1'b0);
    send_window('1, 1'b1);
    // prefix run reaching the limit
    w = rand_window();
    for (int k = 0; k < PREFIX_LIMIT; k++) w[8*k +: 8] = pick_prefix();
    send_window(w, 1'($urandom_range(1)));
    // longest form: fifteen prefixes, c7 with sib, disp32 and imm32
    send_window(put_bytes(prefix_run(rand_window(), 15, PFX_DS), 15, 64'hc784, 2), 1'b1);
    // bit test at the window end, sib byte falls past it
    send_window(put_bytes(prefix_run(rand_window(), 15, PFX_LOCK), 15, 64'h0fba04, 3), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h0fba0425, 4), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h0fba0425, 4), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'h0fb244, 3), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h0fb480, 3), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'h0fb5c1, 3), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h0f05, 2), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'hd8c0, 2), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'he8, 1), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'h66e8, 2), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'h9a, 1), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h66ea, 2), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'hc8, 1), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'hf600, 2), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'hf610, 2), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'hf708, 2), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'hf7d8, 2), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'h67a1, 2), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h8b0c65, 3), 1'b1);
    send_window(put_bytes(rand_window(), 0, 64'h678b0c25, 4), 1'b0);
    send_window(put_bytes(rand_window(), 0, 64'h8b06, 2), 1'b0);
  endtask

  task automatic test_opcode_sweep();
    logic [143:0] w;
    for (int op = 0; op < 256; op++) begin
      w = rand_window();
      w[7:0] = 8'(op);
      send_window(w, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_stream(input int count);
    logic [143:0] w;
    logic         d32;
    for (int i = 0; i < count; i++) begin
      gen_instruction(w, d32);
      send_window(w, d32);
    end
  endtask

  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    test_random_stream(100);
    gap_pct   = 12;
    stall_pct = 12;
  endtask

  task automatic test_drain_pause();
    test_random_stream(30);
    in_ch.valid <= 1'b0;
    wait_for_lengths();
    test_random_stream(30);
  endtask

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.code_bytes_lo  <= '0;
    in_ch.code_bytes_mid <= '0;
    in_ch.code_bytes_hi  <= '0;
    in_ch.default_32     <= 1'b0;
    rst_n                <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_opcode_sweep();
    test_random_stream(300);
    test_back_to_back();
    test_drain_pause();

    in_ch.valid <= 1'b0;
    wait_for_lengths();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (pending_lengths.size() != 0)
      report_mismatch($sformatf("%0d lengths never arrived", pending_lengths.size()));

    $display("decoded %0d code windows (%0d with 16-bit default), opcode sweep included",
             windows_sent, windows_16bit);
    $display("%0d gave length 0, longest instruction %0d bytes, %0d mismatches",
             zero_lengths, longest, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
